[hdl/dle_pkg.sv]
// Shared types, character codes and sequence tables for the DLE character stuffer.
`timescale 1ns / 1ps

package dle_pkg;

    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_SP = 8'h20;

    // Slot layout of one item's output run: header, stuffing, data, trailer.
    localparam int SLOT_COUNT = 20;
    localparam int SLOT_W     = 5;

    localparam logic [SLOT_W-1:0] SLOT_HDR_FIRST = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_HDR_LAST  = 5'd6;
    localparam logic [SLOT_W-1:0] SLOT_STF_FIRST = 5'd7;
    localparam logic [SLOT_W-1:0] SLOT_STF_LAST  = 5'd9;
    localparam logic [SLOT_W-1:0] SLOT_DAT_FIRST = 5'd10;
    localparam logic [SLOT_W-1:0] SLOT_DAT_LAST  = 5'd12;
    localparam logic [SLOT_W-1:0] SLOT_TRL_FIRST = 5'd13;
    localparam logic [SLOT_W-1:0] SLOT_TRL_LAST  = 5'd19;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    typedef logic [SLOT_COUNT-1:0] slot_mask_t;

    // What one accepted item asks the back end to emit.
    typedef struct packed {
        logic            hdr;
        logic            stuff;
        logic [2:0]      dat_en;
        logic            trl;
        logic [2:0][7:0] dat;
    } desc_t;

    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CH_D;
            3'd1:    c = CH_L;
            3'd2:    c = CH_E;
            3'd3:    c = CH_SP;
            3'd4:    c = CH_S;
            3'd5:    c = CH_T;
            default: c = CH_X;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CH_D;
            3'd1:    c = CH_L;
            3'd2:    c = CH_E;
            3'd3:    c = CH_SP;
            3'd4:    c = CH_E;
            3'd5:    c = CH_T;
            default: c = CH_X;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] slot_char(input logic [SLOT_W-1:0] slot,
                                             input logic [2:0][7:0] dat);
        logic [7:0] c;
        logic [SLOT_W-1:0] off;
        off = '0;
        priority if (slot <= SLOT_HDR_LAST)
        begin
            c = header_char(slot[2:0]);
        end
        else if (slot <= SLOT_STF_LAST)
        begin
            off = slot - SLOT_STF_FIRST;
            c = header_char(off[2:0]);
        end
        else if (slot <= SLOT_DAT_LAST)
        begin
            off = slot - SLOT_DAT_FIRST;
            c = dat[off[1:0]];
        end
        else
        begin
            off = slot - SLOT_TRL_FIRST;
            c = trailer_char(off[2:0]);
        end
        return c;
    endfunction

    function automatic slot_mask_t build_mask(input desc_t d);
        slot_mask_t m;
        m = '0;
        m[SLOT_HDR_LAST:SLOT_HDR_FIRST] = {7{d.hdr}};
        m[SLOT_STF_LAST:SLOT_STF_FIRST] = {3{d.stuff}};
        m[SLOT_DAT_LAST:SLOT_DAT_FIRST] = d.dat_en;
        m[SLOT_TRL_LAST:SLOT_TRL_FIRST] = {7{d.trl}};
        return m;
    endfunction

    function automatic logic is_flag(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
        return (a == CH_D && b == CH_L && c == CH_E) ||
               (a == CH_S && b == CH_T && c == CH_X) ||
               (a == CH_E && b == CH_T && c == CH_X);
    endfunction

endpackage

[hdl/dle_front.sv]
// Front end: holds the lookahead window and classifies each input item.
`timescale 1ns / 1ps

module dle_front
    import dle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_char,
    input  logic       msg_last,
    input  logic       q_full,
    output logic       q_push,
    output desc_t      q_desc
);

    logic [7:0] older_reg, older_next;
    logic [7:0] newer_reg, newer_next;
    logic [1:0] held_reg, held_next;
    logic       accept;
    logic       has_run;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        q_desc     = '0;
        has_run    = 1'b1;
        older_next = older_reg;
        newer_next = newer_reg;
        held_next  = held_reg;
        unique case (held_reg)
            HELD_NONE:
            begin
                q_desc.hdr = 1'b1;
                if (msg_last)
                begin
                    q_desc.dat_en = 3'b001;
                    q_desc.dat[0] = data_char;
                end
                else
                begin
                    older_next = data_char;
                    held_next  = HELD_ONE;
                end
            end
            HELD_ONE:
            begin
                if (msg_last)
                begin
                    q_desc.dat_en = 3'b011;
                    q_desc.dat[0] = older_reg;
                    q_desc.dat[1] = data_char;
                end
                else
                begin
                    has_run    = 1'b0;
                    newer_next = data_char;
                    held_next  = HELD_TWO;
                end
            end
            default:
            begin
                q_desc.stuff  = is_flag(older_reg, newer_reg, data_char);
                q_desc.dat[0] = older_reg;
                q_desc.dat[1] = newer_reg;
                q_desc.dat[2] = data_char;
                q_desc.dat_en = msg_last ? 3'b111 : 3'b001;
                older_next    = newer_reg;
                newer_next    = data_char;
                held_next     = HELD_TWO;
            end
        endcase
        q_desc.trl = msg_last;
        // Close the frame: back to idle.
        if (msg_last)
        begin
            older_next = '0;
            newer_next = '0;
            held_next  = HELD_NONE;
        end
    end

    assign q_push = accept && has_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            held_reg  <= HELD_NONE;
        end
        else if (accept)
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            held_reg  <= held_next;
        end
    end

endmodule

[hdl/dle_queue.sv]
// Short descriptor queue between the front end and the back end.
`timescale 1ns / 1ps

module dle_queue
    import dle_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[hdl/dle_back.sv]
// Back end: expands each descriptor into output characters, one per cycle while out_stall is low.
`timescale 1ns / 1ps

module dle_back
    import dle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  desc_t      q_desc,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_end,
    output logic       frame_end
);

    slot_mask_t       rem_reg, rem_next;
    logic [2:0][7:0]  dat_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg;
    logic             run_end_reg;
    logic             frame_end_reg;
    slot_mask_t       low_bit;
    logic [SLOT_W-1:0] slot;
    logic             active;
    logic             fire;
    logic             last_slot;
    logic             load;

    assign active    = (rem_reg != '0);
    assign fire      = active && (!out_valid_reg || !out_stall);
    assign low_bit   = rem_reg & (~rem_reg + 1'b1);
    assign last_slot = ((rem_reg & (rem_reg - 1'b1)) == '0);
    assign load      = q_valid && (!active || (fire && last_slot));
    assign q_pop     = load;

    always_comb
    begin
        slot = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (low_bit[i])
            begin
                slot = slot | SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        if (load)
        begin
            rem_next = build_mask(q_desc);
        end
        else if (fire)
        begin
            rem_next = rem_reg & ~low_bit;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dat_reg <= q_desc.dat;
        end
        if (fire)
        begin
            out_char_reg  <= slot_char(slot, dat_reg);
            run_end_reg   <= last_slot;
            frame_end_reg <= (slot == SLOT_TRL_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_end   = run_end_reg;
    assign frame_end = frame_end_reg;

endmodule

[hdl/dle_character_stuffer.sv]
// Top level of the DLE character stuffer: front end, descriptor queue, back end.
`timescale 1ns / 1ps

// Frames a message with the "DLE STX" header and "DLE ETX" trailer and
// inserts D, L, E ahead of every character that starts DLE, STX or ETX.
// Input and output both use valid/stall. The output delivers one character
// per cycle while it has characters to send and out_stall is low. An input
// item is held up only while the descriptor queue (QUEUE_DEPTH entries) is
// full, and each queued item makes the back end produce 1 to 15 characters
// (7 at a frame start, 1 or 4 mid-message, 9 for a two-character message,
// 10 or 13 at the end of a longer message, 15 for a one-character message).
module dle_character_stuffer
    import dle_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_char,
    input  logic       msg_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_end,
    output logic       frame_end
);

    logic  q_full;
    logic  q_push;
    desc_t q_push_desc;
    logic  q_pop;
    logic  q_head_valid;
    desc_t q_head_desc;

    dle_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_char (data_char),
        .msg_last  (msg_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (q_push_desc)
    );

    dle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_desc  (q_head_desc)
    );

    dle_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_head_valid),
        .q_desc    (q_head_desc),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .run_end   (run_end),
        .frame_end (frame_end)
    );

endmodule
